// ----- rtl/core/fblm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblm_pkg
// Shared types and constants of the flow line blockage monitor.
// ----------------------------------------------------------------------------
package fblm_pkg;

  localparam int LINES    = 4;
  localparam int MASK_W   = LINES + 1;
  localparam int TOTAL_W  = 32;
  localparam int BUCKET_W = 16;
  localparam int RATE_W   = 12;
  localparam int TIMER_W  = 16;
  localparam int THR_W    = 9;
  localparam int SUS_W    = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REG_W    = 2;

  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [TIMER_W-1:0] timer_t;

  localparam rate_t  RATE_MAX      = '1;
  localparam timer_t TICK_SECONDS  = 16'd10;
  localparam timer_t CLEAR_SECONDS = 16'd60;

  localparam logic [REG_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [REG_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [REG_W-1:0] REG_SUSTAIN   = 2'd2;
  localparam logic [REG_W-1:0] REG_BEEP      = 2'd3;

  typedef struct packed {
    logic             enable;
    logic [THR_W-1:0] threshold;
    logic [SUS_W-1:0] sustain;
    logic             beep;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{enable: 1'b1, threshold: 9'd12, sustain: 12'd120, beep: 1'b1};

  typedef struct packed {
    logic full;
    logic silence;
  } tick_t;

  typedef struct packed {
    mask_t alarm;
    mask_t raised;
    mask_t cleared;
    logic  chirp;
    logic  warming;
  } result_t;

  function automatic timer_t timer_add(timer_t t);
    logic [TIMER_W:0] n;
    n = {1'b0, t} + {1'b0, TICK_SECONDS};
    return n[TIMER_W] ? '1 : n[TIMER_W-1:0];
  endfunction

endpackage

// ----- rtl/core/fblm_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblm_lane
// One meter line: pulse delta, bucket window with running sum, and a
// two-stage reciprocal divide that turns the window sum into a rate.
// ----------------------------------------------------------------------------
module fblm_lane #(
  parameter int WINDOW_BUCKETS   = 6,
  parameter int PULSES_PER_LITRE = 1200,
  localparam int SLOT_W          = $clog2(WINDOW_BUCKETS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         primed,
  input  logic [SLOT_W-1:0]            slot,
  input  logic                         ld2,
  input  logic                         ld3,
  input  logic                         full2,
  input  logic [fblm_pkg::TOTAL_W-1:0] pulse_total,
  output fblm_pkg::rate_t              rate
);
  import fblm_pkg::*;

  localparam int SUM_W = BUCKET_W + SLOT_W;
  localparam int X_W   = SUM_W + 4;
  localparam int DIV_W = $clog2(PULSES_PER_LITRE + 1);
  localparam int BK_W  = SUM_W + DIV_W;
  localparam logic [SUM_W-1:0] RECIP   = SUM_W'((longint'(10) << SUM_W) / PULSES_PER_LITRE);
  localparam logic [DIV_W-1:0] DIVISOR = DIV_W'(PULSES_PER_LITRE);

  logic [TOTAL_W-1:0]  prev_r;
  logic [BUCKET_W-1:0] bucket_r [WINDOW_BUCKETS];
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [X_W-1:0]      x10_r, x10_nxt;
  logic [SUM_W-1:0]    quot_r, quot_nxt;
  rate_t               rate_r, rate_nxt;

  logic [TOTAL_W-1:0]  delta;
  logic [BUCKET_W-1:0] bucket_in;
  logic [2*SUM_W-1:0]  prod;
  logic [BK_W-1:0]     back;
  logic [X_W-1:0]      rem;
  logic [SUM_W-1:0]    quot_fix;

  always_comb begin
    delta     = pulse_total - prev_r;
    bucket_in = !primed ? '0 : ((|delta[TOTAL_W-1:BUCKET_W]) ? '1 : delta[BUCKET_W-1:0]);
    sum_nxt   = sum_r - SUM_W'(bucket_r[slot]) + SUM_W'(bucket_in);
    prod      = (2*SUM_W)'(sum_r) * (2*SUM_W)'(RECIP);
    quot_nxt  = prod[2*SUM_W-1:SUM_W];
    x10_nxt   = (X_W'(sum_r) << 3) + (X_W'(sum_r) << 1);
    back      = BK_W'(quot_r) * BK_W'(DIVISOR);
    rem       = x10_r - back[X_W-1:0];
    quot_fix  = quot_r + SUM_W'(rem >= X_W'(DIVISOR));
    rate_nxt  = (quot_fix > SUM_W'(RATE_MAX)) ? RATE_MAX : quot_fix[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      bucket_r <= '{default: '0};
      sum_r    <= '0;
      rate_r   <= '0;
    end else begin
      if (accept) begin
        prev_r         <= pulse_total;
        bucket_r[slot] <= bucket_in;
        sum_r          <= sum_nxt;
      end
      if (ld3 && full2) begin
        rate_r <= rate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      x10_r  <= x10_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rate = rate_r;

endmodule

// ----- rtl/core/fblm_judge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblm_judge
// Merges the lane rates: line and supply timers, alarm state, acknowledge
// and chirp, and holds the output register of the result beat.
// ----------------------------------------------------------------------------
module fblm_judge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  logic                clear,
  input  fblm_pkg::cfg_t      cfg,
  input  fblm_pkg::tick_t     tick,
  input  fblm_pkg::rate_t     rates [fblm_pkg::LINES],
  output fblm_pkg::result_t   result,
  output fblm_pkg::rate_t     rates_out [fblm_pkg::LINES]
);
  import fblm_pkg::*;

  timer_t           low_t_r [LINES];
  timer_t           ok_t_r  [LINES];
  logic [LINES-1:0] line_r;
  logic             sup_r;
  timer_t           all_low_r, all_ok_r;
  logic             sil_r;

  result_t          res_r;
  rate_t            rate_out_r [LINES];

  timer_t           low_t_nxt [LINES];
  timer_t           ok_t_nxt  [LINES];
  logic [LINES-1:0] line_nxt, low, ok, ln_raise, ln_clear;
  logic             sup_nxt, sup_raise, sup_clear;
  timer_t           all_low_nxt, all_ok_nxt, sus, lt_base;
  logic             judge, sil_tmp, sil_nxt, any, chirp;
  mask_t            raised, cleared;

  always_comb begin
    sus       = TIMER_W'(cfg.sustain);
    judge     = tick.full && cfg.enable;
    sil_tmp   = sil_r | tick.silence;
    lt_base   = '0;
    for (int g = 0; g < LINES; g++) begin
      low[g] = rates[g] < RATE_W'(cfg.threshold);
      ok[g]  = rates[g] > RATE_W'(cfg.threshold);
    end
    all_low_nxt = (&low) ? timer_add(all_low_r) : '0;
    all_ok_nxt  = (&low) ? '0 : timer_add(all_ok_r);
    sup_raise   = !sup_r && (all_low_nxt >= sus);
    sup_clear   = sup_r && (all_ok_nxt >= CLEAR_SECONDS);
    sup_nxt     = (sup_r | sup_raise) & !sup_clear;
    for (int g = 0; g < LINES; g++) begin
      lt_base      = sup_raise ? '0 : low_t_r[g];
      low_t_nxt[g] = low[g] ? timer_add(lt_base) : '0;
      ok_t_nxt[g]  = ok[g] ? timer_add(ok_t_r[g]) : '0;
      ln_raise[g]  = !line_r[g] && !sup_nxt && (low_t_nxt[g] >= sus);
      ln_clear[g]  = line_r[g] && (ok_t_nxt[g] >= CLEAR_SECONDS);
      line_nxt[g]  = (line_r[g] | ln_raise[g]) & !ln_clear[g];
    end
    raised  = {sup_raise, ln_raise};
    cleared = {sup_clear, ln_clear};
    any     = (|line_nxt) | sup_nxt;
    sil_nxt = sil_tmp && !(|raised) && any;
    chirp   = any && cfg.beep && !sil_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_t_r   <= '{default: '0};
      ok_t_r    <= '{default: '0};
      line_r    <= '0;
      sup_r     <= 1'b0;
      all_low_r <= '0;
      all_ok_r  <= '0;
      sil_r     <= 1'b0;
    end else if (clear) begin
      low_t_r   <= '{default: '0};
      ok_t_r    <= '{default: '0};
      line_r    <= '0;
      sup_r     <= 1'b0;
      all_low_r <= '0;
      all_ok_r  <= '0;
    end else if (ld) begin
      if (judge) begin
        low_t_r   <= low_t_nxt;
        ok_t_r    <= ok_t_nxt;
        line_r    <= line_nxt;
        sup_r     <= sup_nxt;
        all_low_r <= all_low_nxt;
        all_ok_r  <= all_ok_nxt;
        sil_r     <= sil_nxt;
      end else begin
        sil_r <= sil_tmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r.alarm   <= judge ? {sup_nxt, line_nxt} : {sup_r, line_r};
      res_r.raised  <= judge ? raised : '0;
      res_r.cleared <= judge ? cleared : '0;
      res_r.chirp   <= judge && chirp;
      res_r.warming <= !tick.full;
      rate_out_r    <= rates;
    end
  end

  assign result    = res_r;
  assign rates_out = rate_out_r;

endmodule

// ----- rtl/core/flow_line_blockage_monitor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_line_blockage_monitor_core
// Low-flow monitor for four metered lines with per-line and supply alarms.
//
// One input beat is one 10 s tick: four cumulative pulse totals plus an
// acknowledge flag. Each tick yields exactly one result beat with the alarm
// masks, four rates in tenths of L/min, a chirp request and a warm-up flag.
// Both channels are valid/ready; the APB port sets enable, threshold,
// sustain time and beep enable (byte addresses 0, 4, 8, 12).
// Four lanes run side by side (delta, window, divide) and a merging stage
// judges the alarms. Each tick passes the four-register pipeline (window,
// multiply, divide correction, judgement); throughput is one tick per cycle
// while the receiver keeps out_ready high. Reset clears the window, rates,
// timers and alarms and loads the register defaults; no clearing pass is
// needed. When the receiver stalls the pipeline fills up to four ticks, then
// in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module flow_line_blockage_monitor_core #(
  parameter int WINDOW_BUCKETS   = 6,
  parameter int PULSES_PER_LITRE = 1200
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fblm_pkg::TOTAL_W-1:0] in_pulse_total_a,
  input  logic [fblm_pkg::TOTAL_W-1:0] in_pulse_total_b,
  input  logic [fblm_pkg::TOTAL_W-1:0] in_pulse_total_c,
  input  logic [fblm_pkg::TOTAL_W-1:0] in_pulse_total_d,
  input  logic                         in_silence_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fblm_pkg::mask_t              out_alarm_mask,
  output fblm_pkg::mask_t              out_raised_mask,
  output fblm_pkg::mask_t              out_cleared_mask,
  output fblm_pkg::rate_t              out_rate_a,
  output fblm_pkg::rate_t              out_rate_b,
  output fblm_pkg::rate_t              out_rate_c,
  output fblm_pkg::rate_t              out_rate_d,
  output logic                         out_chirp,
  output logic                         out_warming_up,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fblm_pkg::ADDR_W-1:0]  paddr,
  input  logic [fblm_pkg::DATA_W-1:0]  pwdata,
  output logic [fblm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import fblm_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_BUCKETS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BUCKETS - 1);

  cfg_t              cfg_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              primed_r, full_r;
  logic              v1_r, v2_r, v3_r, out_valid_r;
  logic              sil1_r;
  tick_t             tick2_r, tick3_r;

  logic              rdy_o, rdy3, rdy2, accept, ld2, ld3, ldo;
  logic              wr, clear;
  logic [REG_W-1:0]  reg_idx;

  logic [TOTAL_W-1:0] pulse [LINES];
  rate_t              lane_rate [LINES];
  rate_t              rate_out  [LINES];
  result_t            result;

  // pipeline flow
  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_o;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = !v1_r || rdy2;
  assign accept   = in_valid && in_ready;
  assign ld2      = v1_r && rdy2;
  assign ld3      = v2_r && rdy3;
  assign ldo      = v3_r && rdy_o;

  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      primed_r    <= 1'b0;
      full_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        slot_r   <= slot_nxt;
        primed_r <= 1'b1;
        full_r   <= full_r | (slot_r == SLOT_LAST);
      end
      if (in_ready) v1_r <= in_valid;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy_o)    out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) sil1_r <= in_silence_request;
    if (ld2) begin
      tick2_r.full    <= full_r;
      tick2_r.silence <= sil1_r;
    end
    if (ld3) tick3_r <= tick2_r;
  end

  // configuration
  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign clear   = wr && (reg_idx == REG_ENABLE) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_ENABLE:    cfg_r.enable    <= pwdata[0];
        REG_THRESHOLD: cfg_r.threshold <= pwdata[THR_W-1:0];
        REG_SUSTAIN:   cfg_r.sustain   <= pwdata[SUS_W-1:0];
        REG_BEEP:      cfg_r.beep      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:    prdata = DATA_W'(cfg_r.enable);
      REG_THRESHOLD: prdata = DATA_W'(cfg_r.threshold);
      REG_SUSTAIN:   prdata = DATA_W'(cfg_r.sustain);
      REG_BEEP:      prdata = DATA_W'(cfg_r.beep);
      default:       prdata = '0;
    endcase
  end

  // lanes
  assign pulse[0] = in_pulse_total_a;
  assign pulse[1] = in_pulse_total_b;
  assign pulse[2] = in_pulse_total_c;
  assign pulse[3] = in_pulse_total_d;

  for (genvar g = 0; g < LINES; g++) begin : g_lane
    fblm_lane #(
      .WINDOW_BUCKETS   (WINDOW_BUCKETS),
      .PULSES_PER_LITRE (PULSES_PER_LITRE)
    ) u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .primed      (primed_r),
      .slot        (slot_r),
      .ld2         (ld2),
      .ld3         (ld3),
      .full2       (tick2_r.full),
      .pulse_total (pulse[g]),
      .rate        (lane_rate[g])
    );
  end

  fblm_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ldo),
    .clear     (clear),
    .cfg       (cfg_r),
    .tick      (tick3_r),
    .rates     (lane_rate),
    .result    (result),
    .rates_out (rate_out)
  );

  assign out_valid        = out_valid_r;
  assign out_alarm_mask   = result.alarm;
  assign out_raised_mask  = result.raised;
  assign out_cleared_mask = result.cleared;
  assign out_chirp        = result.chirp;
  assign out_warming_up   = result.warming;
  assign out_rate_a       = rate_out[0];
  assign out_rate_b       = rate_out[1];
  assign out_rate_c       = rate_out[2];
  assign out_rate_d       = rate_out[3];

endmodule

// ----- tb/sv/tb_flow_line_blockage_monitor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_line_blockage_monitor_core
// Self-checking bench for the flow line blockage monitor core.
//
// Ticks of four wrapping meter totals go in as beats, in bursts with random
// gaps, while the result side stalls on its own pattern. A scoreboard keeps
// its own copy of the rate window, the low/ok timers, the alarms and the
// registers, predicts one result per accepted tick and checks every result
// beat field by field. A short directed opening covers priming, counter wrap
// and bucket saturation; random phases then sweep the register settings
// (disabled, zero sustain, zero and top threshold, beep off) over scenes of
// low, borderline, healthy and saturating flow; a closing soak holds every
// line low under a supply alarm, then lets three lines recover.
// ----------------------------------------------------------------------------
module tb_flow_line_blockage_monitor_core;
  import fblm_pkg::*;

  localparam int NBUCKET     = 6;
  localparam int PPL         = 1200;
  localparam int MAX_CYCLES  = 1_000_000;
  localparam int PHASE_TICKS = 90;
  localparam int SOAK_TICKS  = 80;

  typedef struct packed {
    logic [LINES-1:0][TOTAL_W-1:0] total;
    logic                          silence;
  } tick_in_t;

  typedef struct packed {
    mask_t             alarm;
    mask_t             raised;
    mask_t             cleared;
    rate_t [LINES-1:0] rate;
    logic              chirp;
    logic              warming;
  } tick_out_t;

  class blockage_scoreboard;
    bit                  enable;
    bit [THR_W-1:0]      threshold;
    bit [SUS_W-1:0]      sustain;
    bit                  beep;

    bit [TOTAL_W-1:0]    last_total[LINES];
    bit [BUCKET_W-1:0]   bucket[LINES][NBUCKET];
    int                  slot;
    bit                  full;
    bit                  primed;
    bit [RATE_W-1:0]     rate[LINES];
    bit [TIMER_W-1:0]    low_time[LINES];
    bit [TIMER_W-1:0]    ok_time[LINES];
    bit [TIMER_W-1:0]    all_low_time;
    bit [TIMER_W-1:0]    all_ok_time;
    bit                  line_alarm[LINES];
    bit                  supply_alarm;
    bit                  silenced;

    tick_out_t           due[$];
    string               rate_name[LINES] = '{"rate_a", "rate_b", "rate_c", "rate_d"};
    int                  fails;
    int                  checked;
    int                  raised_seen;
    int                  cleared_seen;
    int                  chirps;

    function new();
      enable    = CFG_RESET.enable;
      threshold = CFG_RESET.threshold;
      sustain   = CFG_RESET.sustain;
      beep      = CFG_RESET.beep;
    endfunction

    function bit [TIMER_W-1:0] bump(bit [TIMER_W-1:0] t);
      return (t > {TIMER_W{1'b1}} - TICK_SECONDS) ? {TIMER_W{1'b1}} : t + TICK_SECONDS;
    endfunction

    function void drop_alarms();
      int g;
      for (g = 0; g < LINES; g++) begin
        line_alarm[g] = 0;
        low_time[g]   = '0;
        ok_time[g]    = '0;
      end
      supply_alarm = 0;
      all_low_time = '0;
      all_ok_time  = '0;
    endfunction

    function void write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_ENABLE: begin
          enable = value[0];
          if (!enable) drop_alarms();
        end
        REG_THRESHOLD: threshold = value[THR_W-1:0];
        REG_SUSTAIN:   sustain   = value[SUS_W-1:0];
        REG_BEEP:      beep      = value[0];
        default: ;
      endcase
    endfunction

    function void note_tick(tick_in_t t);
      bit [TOTAL_W-1:0] d;
      bit [31:0]        sum;
      bit [31:0]        r;
      bit               low[LINES];
      int               g;
      int               k;
      int               nlow;
      bit               any;
      tick_out_t        e;
      e    = '0;
      nlow = 0;
      any  = 0;
      if (t.silence) silenced = 1;
      for (g = 0; g < LINES; g++) begin
        d = t.total[g] - last_total[g];
        last_total[g] = t.total[g];
        if (!primed) d = '0;
        bucket[g][slot] = (d > 32'd65535) ? {BUCKET_W{1'b1}} : d[BUCKET_W-1:0];
      end
      primed = 1;
      slot = (slot + 1) % NBUCKET;
      if (slot == 0) full = 1;
      if (full) begin
        for (g = 0; g < LINES; g++) begin
          sum = '0;
          for (k = 0; k < NBUCKET; k++) sum = sum + bucket[g][k];
          r = (sum * 10) / PPL;
          rate[g] = (r > RATE_MAX) ? RATE_MAX : r[RATE_W-1:0];
          low[g] = rate[g] < threshold;
          if (low[g]) nlow++;
        end
        if (enable) begin
          if (nlow == LINES) begin
            all_low_time = bump(all_low_time);
            all_ok_time  = '0;
          end else begin
            all_low_time = '0;
            all_ok_time  = bump(all_ok_time);
          end
          if (!supply_alarm && all_low_time >= sustain) begin
            supply_alarm = 1;
            e.raised[LINES] = 1'b1;
            silenced = 0;
            for (g = 0; g < LINES; g++) low_time[g] = '0;
          end else if (supply_alarm && all_ok_time >= CLEAR_SECONDS) begin
            supply_alarm = 0;
            e.cleared[LINES] = 1'b1;
          end
          for (g = 0; g < LINES; g++) begin
            low_time[g] = low[g] ? bump(low_time[g]) : '0;
            if (rate[g] >= threshold + 1) ok_time[g] = bump(ok_time[g]);
            else ok_time[g] = '0;
            if (!line_alarm[g] && !supply_alarm && low_time[g] >= sustain) begin
              line_alarm[g] = 1;
              e.raised[g] = 1'b1;
              silenced = 0;
            end else if (line_alarm[g] && ok_time[g] >= CLEAR_SECONDS) begin
              line_alarm[g] = 0;
              e.cleared[g] = 1'b1;
            end
            if (line_alarm[g]) any = 1;
          end
          if (supply_alarm) any = 1;
          if (!any) silenced = 0;
          e.chirp = any && beep && !silenced;
        end
      end
      for (g = 0; g < LINES; g++) begin
        e.alarm[g] = line_alarm[g];
        e.rate[g]  = rate[g];
      end
      e.alarm[LINES] = supply_alarm;
      e.warming = !full;
      due.push_back(e);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        fails++;
      end
    endfunction

    function void check_result(tick_out_t got);
      tick_out_t e;
      int        g;
      if (due.size() == 0) begin
        $error("result beat with no tick outstanding");
        fails++;
        return;
      end
      e = due.pop_front();
      checked++;
      if (e.raised != '0) raised_seen++;
      if (e.cleared != '0) cleared_seen++;
      if (e.chirp) chirps++;
      compare("alarm_mask", e.alarm, got.alarm);
      compare("raised_mask", e.raised, got.raised);
      compare("cleared_mask", e.cleared, got.cleared);
      for (g = 0; g < LINES; g++) compare(rate_name[g], e.rate[g], got.rate[g]);
      compare("chirp", e.chirp, got.chirp);
      compare("warming_up", e.warming, got.warming);
    endfunction
  endclass

  logic                clk;
  logic                rst_n              = 1'b0;
  logic                in_valid           = 1'b0;
  logic                in_ready;
  logic [TOTAL_W-1:0]  in_pulse_total_a   = '0;
  logic [TOTAL_W-1:0]  in_pulse_total_b   = '0;
  logic [TOTAL_W-1:0]  in_pulse_total_c   = '0;
  logic [TOTAL_W-1:0]  in_pulse_total_d   = '0;
  logic                in_silence_request = 1'b0;
  logic                out_valid;
  logic                out_ready          = 1'b0;
  mask_t               out_alarm_mask;
  mask_t               out_raised_mask;
  mask_t               out_cleared_mask;
  rate_t               out_rate_a;
  rate_t               out_rate_b;
  rate_t               out_rate_c;
  rate_t               out_rate_d;
  logic                out_chirp;
  logic                out_warming_up;
  logic                psel               = 1'b0;
  logic                penable            = 1'b0;
  logic                pwrite             = 1'b0;
  logic [ADDR_W-1:0]   paddr              = '0;
  logic [DATA_W-1:0]   pwdata             = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  blockage_scoreboard  sb = new();

  logic [TOTAL_W-1:0]  meter[LINES];
  int                  flow[LINES];
  int                  cur_thr     = 12;
  int                  burst_left  = 0;
  int                  sent        = 0;
  int unsigned         cycle_count = 0;
  int                  rx_mode     = 0;
  int                  rx_span     = 0;
  int                  rx_hold     = 0;

  flow_line_blockage_monitor_core #(
    .WINDOW_BUCKETS  (NBUCKET),
    .PULSES_PER_LITRE(PPL)
  ) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: spans of always-ready, coin-toss ready and stall bursts
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_span <= $urandom_range(20, 80);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: begin
        if (rx_hold != 0) begin
          out_ready <= 1'b0;
          rx_hold   <= rx_hold - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    tick_out_t got;
    if (rst_n && out_valid && out_ready) begin
      got.alarm   = out_alarm_mask;
      got.raised  = out_raised_mask;
      got.cleared = out_cleared_mask;
      got.rate[0] = out_rate_a;
      got.rate[1] = out_rate_b;
      got.rate[2] = out_rate_c;
      got.rate[3] = out_rate_d;
      got.chirp   = out_chirp;
      got.warming = out_warming_up;
      sb.check_result(got);
    end
  end

  task automatic send_tick(tick_in_t t);
    in_valid           <= 1'b1;
    in_pulse_total_a   <= t.total[0];
    in_pulse_total_b   <= t.total[1];
    in_pulse_total_c   <= t.total[2];
    in_pulse_total_d   <= t.total[3];
    in_silence_request <= t.silence;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
    sent++;
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  // back-to-back writes keep psel high between transfers
  task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value, bit last);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  task automatic configure(bit en, int thr, int sus, bit bp);
    logic [DATA_W-1:0] hi;
    hi = $urandom();
    write_reg(REG_ENABLE, (hi & ~32'h1) | en, 1'b0);
    write_reg(REG_THRESHOLD, (hi & ~32'h1FF) | thr, 1'b0);
    write_reg(REG_SUSTAIN, (hi & ~32'hFFF) | sus, 1'b0);
    write_reg(REG_BEEP, (hi & ~32'h1) | bp, 1'b1);
    cur_thr = thr;
  endtask

  function automatic tick_in_t from_meter(bit sil);
    tick_in_t t;
    int       g;
    for (g = 0; g < LINES; g++) t.total[g] = meter[g];
    t.silence = sil;
    return t;
  endfunction

  // rate is roughly per-tick delta / 20, so 20 * threshold marks the edge
  function automatic int pick_flow(int kind);
    case (kind)
      0:       return 0;
      1:       return $urandom_range(0, cur_thr * 16);
      2:       return cur_thr * 20 + $urandom_range(0, 40) - 20;
      3:       return $urandom_range(cur_thr * 20 + 60, 20000);
      default: return $urandom_range(60000, 200000);
    endcase
  endfunction

  function automatic void new_scene();
    int kind;
    int lone;
    int g;
    kind = $urandom_range(0, 3);
    lone = $urandom_range(0, LINES - 1);
    for (g = 0; g < LINES; g++) begin
      case (kind)
        0:       flow[g] = pick_flow($urandom_range(0, 1));
        1:       flow[g] = (g == lone) ? pick_flow($urandom_range(0, 1)) : pick_flow(3);
        2:       flow[g] = pick_flow($urandom_range(0, 4));
        default: flow[g] = pick_flow($urandom_range(2, 4));
      endcase
      if (flow[g] < 0) flow[g] = 0;
    end
  endfunction

  function automatic tick_in_t next_tick(bit glitch, int silence_pct);
    int g;
    for (g = 0; g < LINES; g++) begin
      if (glitch && $urandom_range(0, 99) == 0) meter[g] = $urandom();
      else meter[g] = meter[g] + flow[g] + $urandom_range(0, 15);
    end
    return from_meter($urandom_range(0, 99) < silence_pct);
  endfunction

  initial begin
    int i;
    int p;
    int n;
    int g;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // priming tick at all-ones, wrap to zero, then saturating steps
    foreach (meter[g]) meter[g] = '1;
    send_tick(from_meter(1'b1));
    pace();
    foreach (meter[g]) meter[g] = '0;
    send_tick(from_meter(1'b0));
    pace();
    meter[0] = 32'h0001_0000;
    meter[1] = 32'h0000_FFFF;
    meter[2] = 32'hFFFF_FFFF;
    meter[3] = 32'h0000_0000;
    send_tick(from_meter(1'b0));
    pace();
    for (i = 0; i < 19; i++) begin
      // line b dry, line c trickling: both go low at the default threshold
      meter[0] += 3000;
      meter[2] += 100;
      meter[3] += 300;
      send_tick(from_meter(i == 15));
      pace();
    end

    for (p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: configure(1'b1, 12, 120, 1'b1);
        1: configure(1'b1, 300, 10, 1'b1);
        2: configure(1'b0, 50, 20, 1'b1);
        3: configure(1'b1, 511, 0, 1'b0);
        4: configure(1'b1, 0, 30, 1'b1);
        5: configure(1'b1, 1, 4095, 1'b1);
        6: configure($urandom_range(0, 1), $urandom_range(1, 300), $urandom_range(10, 200),
                     $urandom_range(0, 1));
        default: configure(1'b1, $urandom_range(1, 300), $urandom_range(0, 60), 1'b1);
      endcase
      new_scene();
      for (n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(0, 19) == 0) new_scene();
        for (g = 0; g < LINES; g++)
          if ($urandom_range(0, 49) == 0) flow[g] = pick_flow($urandom_range(0, 4));
        send_tick(next_tick(1'b1, 8));
        pace();
      end
    end

    // soak: all lines low until a supply alarm holds the line alarms off,
    // then only line a stays low
    drain();
    configure(1'b1, 300, 200, 1'b1);
    for (g = 0; g < LINES; g++) flow[g] = $urandom_range(0, 150);
    for (n = 0; n < SOAK_TICKS; n++) begin
      send_tick(next_tick(1'b0, 5));
      pace();
    end
    for (g = 1; g < LINES; g++) flow[g] = 12000;
    for (n = 0; n < 24; n++) begin
      send_tick(next_tick(1'b0, 5));
      pace();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.due.size() != 0) begin
      $error("%0d result beats never arrived", sb.due.size());
      sb.fails++;
    end
    $display("Sent %0d ticks over eight register settings and a %0d-tick low-flow soak.",
             sent, SOAK_TICKS);
    $display("Checked %0d results: %0d raised alarms, %0d cleared alarms, %0d chirps.",
             sb.checked, sb.raised_seen, sb.cleared_seen, sb.chirps);
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
